@@ design/slid_pkg.sv @@
// Shared types, field widths and operation and status codes for the sorted list unit.
`default_nettype none
package slid_pkg;

	localparam int CAPACITY_DEF = 32;

	localparam int FUNC_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic   ins;
		logic   del;
		value_t value;
	} slid_ctrl_t;

endpackage
`default_nettype wire

@@ design/slid_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
`default_nettype none
interface slid_in_if;
	import slid_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	value_t              value;
	logic [INDEX_W-1:0]  index;

	modport source (output valid, output func, output value, output index, input ready);
	modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface slid_out_if;
	import slid_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	value_t              read_value;

	modport source (output valid, output status, output count, output read_value, input ready);
	modport sink   (input valid, input status, input count, input read_value, output ready);
endinterface
`default_nettype wire

@@ design/slid_cell.sv @@
// One list cell: holds an entry, compares it with the request value and shifts with its neighbors.
`default_nettype none
module slid_cell (
	input  wire logic               clk,
	input  wire slid_pkg::slid_ctrl_t ctrl,
	input  wire logic               valid,
	input  wire slid_pkg::value_t   left_entry,
	input  wire logic               left_after,
	input  wire slid_pkg::value_t   right_entry,
	output      slid_pkg::value_t   entry,
	output      logic               after,
	output      logic               eq
);
	import slid_pkg::*;

	value_t entry_q;
	logic   lt_raw;
	logic   eq_raw;
	logic   lt;

	assign lt_raw = entry_q < ctrl.value;
	assign eq_raw = entry_q == ctrl.value;
	assign lt     = valid && lt_raw;
	assign eq     = valid && eq_raw;
	assign after  = !(valid && (lt_raw || eq_raw));
	assign entry  = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_after) begin
				entry_q <= left_entry;
			end else if (after) begin
				entry_q <= ctrl.value;
			end
		end else if (ctrl.del && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

@@ design/sorted_list_insert_delete_unit.sv @@
// Top level: sorted list of signed words built as a row of shifting cells.
//
// Usage: one request beat on req (func, value, index) gives one response beat
// on rsp (status, count, read_value). Insert places the value after all
// entries less than or equal to it; delete removes the first equal entry;
// read returns the entry at index. Every cell compares its entry with the
// request value in parallel and takes its neighbor's entry, the new value or
// keeps its own, so each operation completes in the cycle it is accepted.
// Response: registered; it appears in the cycle after the request beat is accepted.
// Throughput: one request per cycle while rsp.ready is high, as the whole
// cell row compares and shifts at once.
// Reset: the entry count clears to zero and the response register empties;
// the cell contents are not cleared and are never read before written.
// Stall: the response register holds while rsp.ready is low; req.ready is
// low only while a response is held and not taken in the same cycle.
`default_nettype none
module sorted_list_insert_delete_unit #(
	parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	slid_in_if.sink   req,
	slid_out_if.source rsp
);
	import slid_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_next;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  count_out_q;
	value_t              read_value_q;

	value_t              ent [CAPACITY];
	logic [CAPACITY-1:0] after;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] valid;

	logic                accept;
	logic                full;
	logic                found;
	logic                in_range;
	logic [CMP_W-1:0]    idx_ext;
	logic [CMP_W-1:0]    cnt_ext;
	value_t              rd_value;
	logic [STATUS_W-1:0] status_next;
	value_t              rd_next;
	slid_ctrl_t          ctrl;

	assign accept  = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign full    = count_q == CNT_W'(CAPACITY);
	assign found   = |eq;
	assign idx_ext = CMP_W'(req.index);
	assign cnt_ext = CMP_W'(count_q);
	assign in_range = idx_ext < cnt_ext;

	assign ctrl.value = req.value;
	assign ctrl.ins   = accept && (req.func == FUNC_INSERT) && !full;
	assign ctrl.del   = accept && (req.func == FUNC_DELETE) && found;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			value_t left_entry;
			logic   left_after;
			value_t right_entry;

			assign valid[gi] = CNT_W'(gi) < count_q;

			if (gi == 0) begin : g_first
				assign left_entry = req.value;
				assign left_after = 1'b0;
			end else begin : g_mid
				assign left_entry = ent[gi-1];
				assign left_after = after[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign right_entry = ent[gi];
			end else begin : g_inner
				assign right_entry = ent[gi+1];
			end

			slid_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.valid       (valid[gi]),
				.left_entry  (left_entry),
				.left_after  (left_after),
				.right_entry (right_entry),
				.entry       (ent[gi]),
				.after       (after[gi]),
				.eq          (eq[gi])
			);
		end
	endgenerate

	always_comb begin
		rd_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (idx_ext == CMP_W'(i)) begin
				rd_value = ent[i];
			end
		end
	end

	always_comb begin
		count_next  = count_q;
		status_next = ST_DONE;
		rd_next     = '0;
		case (req.func)
			FUNC_INSERT: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			FUNC_DELETE: begin
				if (found) begin
					count_next = count_q - CNT_W'(1);
				end else begin
					status_next = ST_NOT_FOUND;
				end
			end
			FUNC_READ: begin
				if (in_range) begin
					rd_next = rd_value;
				end else begin
					status_next = ST_BAD_INDEX;
				end
			end
			default: begin
				status_next = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_next;
			count_out_q  <= COUNT_W'(count_next);
			read_value_q <= rd_next;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.count      = count_out_q;
	assign rsp.read_value = read_value_q;

endmodule
`default_nettype wire

@@ verif/list_checker.sv @@
// Checker for the sorted list unit: predicts each response and compares it with the block.
module list_checker (
	input logic clk,
	input logic arst_n,
	slid_in_if  req,
	slid_out_if rsp,
	output int  fail_count,
	output int  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import slid_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		value_t              read_value;
	} list_result_t;

	value_t       held [CAPACITY_DEF];
	int unsigned  held_count;
	int           errors;
	list_result_t expected_q [$];

	function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] func,
		input value_t value, input logic [INDEX_W-1:0] index);
		list_result_t r;
		int unsigned  pos;
		int unsigned  i;
		bit           found;
		r.status     = ST_DONE;
		r.read_value = '0;
		case (func)
			FUNC_INSERT: begin
				if (held_count >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					pos = held_count;
					while (pos > 0 && held[pos-1] > value) begin
						held[pos] = held[pos-1];
						pos--;
					end
					held[pos] = value;
					held_count++;
				end
			end
			FUNC_DELETE: begin
				found = 1'b0;
				for (i = 0; i < held_count && !found; i++) begin
					if (held[i] == value) begin
						found = 1'b1;
						for (pos = i; pos + 1 < held_count; pos++)
							held[pos] = held[pos+1];
						held_count--;
					end
				end
				if (!found)
					r.status = ST_NOT_FOUND;
			end
			FUNC_READ: begin
				if (index < held_count)
					r.read_value = held[index];
				else
					r.status = ST_BAD_INDEX;
			end
			default: begin
			end
		endcase
		r.count = held_count[COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t got;
		list_result_t want;
		if (!arst_n) begin
			held_count = 0;
			errors = 0;
			expected_q.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.status     = rsp.status;
				got.count      = rsp.count;
				got.read_value = rsp.read_value;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: response beat with none pending: status %0d count %0d value %0d",
							$realtime, got.status, got.count, got.read_value);
				end else begin
					want = expected_q.pop_front();
					if (got.status !== want.status || got.count !== want.count
						|| got.read_value !== want.read_value) begin
						errors++;
						if (errors <= 10)
							$display("%0t: response mismatch: expected status %0d count %0d value %0d, got status %0d count %0d value %0d",
								$realtime, want.status, want.count, want.read_value,
								got.status, got.count, got.read_value);
					end
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(apply_list_op(req.func, req.value, req.index));
			fail_count <= errors;
			outstanding <= expected_q.size();
		end
	end
endmodule

@@ verif/tb_top.sv @@
// Testbench top for the sorted list unit: clock, reset, request and response traffic, verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import slid_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int ITEM_TARGET  = 1300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   steady;
	int     fail_count;
	int     outstanding;
	int     cycles = 0;
	int     items_sent = 0;
	value_t pool [12];

	slid_in_if  req_ch();
	slid_out_if rsp_ch();

	sorted_list_insert_delete_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	list_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= steady || ($urandom_range(99) >= 9);
		end
	end

	task automatic send_beat(input logic [FUNC_W-1:0] func, input value_t value,
		input logic [INDEX_W-1:0] index);
		req_ch.valid <= 1'b1;
		req_ch.func  <= func;
		req_ch.value <= value;
		req_ch.index <= index;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic idle_gap();
		int n;
		n = $urandom_range(4, 1);
		req_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_all_answered();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic value_t pick_value();
		if ($urandom_range(99) < 70)
			return pool[$urandom_range(11)];
		return value_t'($urandom);
	endfunction

	initial begin
		int                  len;
		int                  roll;
		bit                  quiet;
		op_mix_t             mix;
		logic [FUNC_W-1:0]   f;
		arst_n       = 1'b0;
		steady       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func  = FUNC_READ;
		req_ch.value = '0;
		req_ch.index = '0;
		pool[0] = '0;
		pool[1] = -1;
		pool[2] = 1;
		pool[3] = 32'h7FFF_FFFF;
		pool[4] = 32'h8000_0000;
		for (int k = 5; k < 12; k++)
			pool[k] = value_t'($urandom);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(FUNC_READ,   '0,             '0);
		send_beat(FUNC_DELETE, '0,             '0);
		send_beat(FUNC_NONE,   32'h7FFF_FFFF,  5'd31);
		send_beat(FUNC_INSERT, 32'h7FFF_FFFF,  '0);
		send_beat(FUNC_INSERT, 32'h8000_0000,  '0);
		send_beat(FUNC_INSERT, '0,             '0);
		send_beat(FUNC_INSERT, -1,             5'd31);
		send_beat(FUNC_INSERT, '0,             '0);
		send_beat(FUNC_INSERT, 1,              '0);
		send_beat(FUNC_READ,   '0,             5'd0);
		send_beat(FUNC_READ,   '0,             5'd5);
		send_beat(FUNC_READ,   '0,             5'd6);
		send_beat(FUNC_READ,   '1,             5'd31);
		send_beat(FUNC_DELETE, '0,             '0);
		send_beat(FUNC_DELETE, 32'h1234_5678,  '0);
		send_beat(FUNC_DELETE, 32'h8000_0000,  '0);
		send_beat(FUNC_DELETE, 32'h7FFF_FFFF,  '0);
		send_beat(FUNC_READ,   '0,             5'd0);
		send_beat(FUNC_NONE,   '1,             '0);
		send_beat(FUNC_INSERT, 32'h8000_0000,  '1);
		send_beat(FUNC_READ,   '0,             5'd0);
		send_beat(FUNC_READ,   '0,             5'd3);

		while (items_sent < ITEM_TARGET) begin
			mix = op_mix_t'($urandom_range(2));
			len = $urandom_range(80, 30);
			repeat (len) begin
				quiet = items_sent >= 500 && items_sent < 800;
				steady <= quiet;
				if (!quiet && $urandom_range(99) < 9)
					idle_gap();
				roll = $urandom_range(99);
				case (mix)
					MIX_FILL:  f = roll < 80 ? FUNC_INSERT : roll < 88 ? FUNC_DELETE :
						roll < 98 ? FUNC_READ : FUNC_NONE;
					MIX_DRAIN: f = roll < 10 ? FUNC_INSERT : roll < 75 ? FUNC_DELETE :
						roll < 97 ? FUNC_READ : FUNC_NONE;
					default:   f = roll < 40 ? FUNC_INSERT : roll < 70 ? FUNC_DELETE :
						roll < 97 ? FUNC_READ : FUNC_NONE;
				endcase
				send_beat(f, pick_value(), INDEX_W'($urandom_range(31)));
				if (items_sent == 300 || items_sent == 1000)
					wait_all_answered();
			end
		end

		wait_all_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
